// ----- rtl/pdsa_pkg.sv -----
// ----------------------------------------------------------------------------
// pdsa_pkg
// Shared widths, controller states and the controller/datapath interface
// for the proper divisor sum block.
// ----------------------------------------------------------------------------
package pdsa_pkg;

    localparam int NUMBER_BITS = 31;
    localparam int SUM_BITS    = 34;
    // trial divisor never exceeds sqrt(2^NUMBER_BITS) + 1
    localparam int D_BITS      = (NUMBER_BITS + 1) / 2 + 1;
    localparam int SQ_BITS     = NUMBER_BITS + 2;
    localparam int CNT_BITS    = $clog2(NUMBER_BITS);

    localparam int S_TDATA_BITS = ((NUMBER_BITS + 7) / 8) * 8;
    localparam int M_FIELD_BITS = SUM_BITS + 1;
    localparam int M_TDATA_BITS = ((M_FIELD_BITS + 7) / 8) * 8;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TEST,
        ST_DIV,
        ST_ACC,
        ST_FIN
    } state_t;

    typedef struct packed {
        logic load;       // capture number, reset divisor and sum
        logic div_start;  // start a division of number by the divisor
        logic div_step;   // one restoring division step
        logic accum;      // add divisor pair if it divides, next divisor
        logic out_load;   // capture the result into the output register
    } dp_cmd_t;

    typedef struct packed {
        logic sq_over;    // divisor squared exceeds number
    } dp_status_t;

endpackage

// ----- rtl/proper_divisor_sum_abundance.sv -----
// ----------------------------------------------------------------------------
// proper_divisor_sum_abundance
// Sum of proper divisors of a number by trial division, with abundant flag.
// ----------------------------------------------------------------------------
// one number at a time; each trial divisor whose square does not exceed the number takes a test
// state, a bit-serial division of NUMBER_BITS steps and an accumulate state
// a new number is taken while the previous result waits in the output register
// reset: aresetn synchronous, active low; clears controller and valid flag
module proper_divisor_sum_abundance (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [pdsa_pkg::S_TDATA_BITS-1:0]    s_tdata,  // [30:0] number
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [pdsa_pkg::M_TDATA_BITS-1:0]    m_tdata   // [33:0] divisor_sum, [34] abundant
);

    pdsa_pkg::dp_cmd_t               cmd;
    pdsa_pkg::dp_status_t            status;
    logic [pdsa_pkg::SUM_BITS-1:0]   divisor_sum;
    logic                            abundant;

    pdsa_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    pdsa_dp u_dp (
        .aclk        (aclk),
        .number      (s_tdata[pdsa_pkg::NUMBER_BITS-1:0]),
        .cmd         (cmd),
        .status      (status),
        .divisor_sum (divisor_sum),
        .abundant    (abundant)
    );

    assign m_tdata = pdsa_pkg::M_TDATA_BITS'({abundant, divisor_sum});

endmodule

// ----- rtl/pdsa_ctrl.sv -----
// ----------------------------------------------------------------------------
// pdsa_ctrl
// Sequencer: runs the trial divisor loop, counts division steps and owns
// both handshakes.
// ----------------------------------------------------------------------------
module pdsa_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    input  pdsa_pkg::dp_status_t status,
    output pdsa_pkg::dp_cmd_t    cmd
);

    pdsa_pkg::state_t                 state_reg, state_next;
    logic [pdsa_pkg::CNT_BITS-1:0]    cnt_reg, cnt_next;
    logic                             valid_reg, valid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= pdsa_pkg::ST_IDLE;
            cnt_reg   <= '0;
            valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            valid_reg <= valid_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            pdsa_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = pdsa_pkg::ST_TEST;
                end
            end
            pdsa_pkg::ST_TEST: begin
                if (status.sq_over) begin
                    state_next = pdsa_pkg::ST_FIN;
                end else begin
                    cmd.div_start = 1'b1;
                    cnt_next      = '0;
                    state_next    = pdsa_pkg::ST_DIV;
                end
            end
            pdsa_pkg::ST_DIV: begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == pdsa_pkg::CNT_BITS'(pdsa_pkg::NUMBER_BITS - 1)) begin
                    state_next = pdsa_pkg::ST_ACC;
                end
            end
            pdsa_pkg::ST_ACC: begin
                cmd.accum  = 1'b1;
                state_next = pdsa_pkg::ST_TEST;
            end
            pdsa_pkg::ST_FIN: begin
                // wait until the output register is free
                if (!valid_reg || m_tready) begin
                    cmd.out_load = 1'b1;
                    state_next   = pdsa_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = pdsa_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        if (cmd.out_load) begin
            valid_next = 1'b1;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end else begin
            valid_next = valid_reg;
        end
    end

    assign m_tvalid = valid_reg;

endmodule

// ----- rtl/pdsa_dp.sv -----
// ----------------------------------------------------------------------------
// pdsa_dp
// Datapath: number, trial divisor and its square, a radix-2 restoring
// divider, the running sum and the output register.
// ----------------------------------------------------------------------------
module pdsa_dp (
    input  logic                                aclk,
    input  logic [pdsa_pkg::NUMBER_BITS-1:0]    number,
    input  pdsa_pkg::dp_cmd_t                   cmd,
    output pdsa_pkg::dp_status_t                status,
    output logic [pdsa_pkg::SUM_BITS-1:0]       divisor_sum,
    output logic                                abundant
);

    localparam int NB = pdsa_pkg::NUMBER_BITS;
    localparam int DB = pdsa_pkg::D_BITS;
    localparam int SB = pdsa_pkg::SUM_BITS;
    localparam int QB = pdsa_pkg::SQ_BITS;

    logic [NB-1:0] n_reg,   n_next;
    logic [DB-1:0] d_reg,   d_next;
    logic [QB-1:0] sq_reg,  sq_next;
    logic [DB-1:0] rem_reg, rem_next;
    logic [NB-1:0] quo_reg, quo_next;
    logic [SB-1:0] acc_reg, acc_next;
    logic [SB-1:0] sum_reg, sum_next;
    logic          abn_reg, abn_next;

    logic [DB:0]   rem_sh;
    logic          rem_ge;
    logic [DB:0]   rem_sub;
    logic [SB-1:0] pair;

    always_ff @(posedge aclk) begin
        n_reg   <= n_next;
        d_reg   <= d_next;
        sq_reg  <= sq_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        acc_reg <= acc_next;
        sum_reg <= sum_next;
        abn_reg <= abn_next;
    end

    assign rem_sh  = {rem_reg, quo_reg[NB-1]};
    assign rem_ge  = rem_sh >= {1'b0, d_reg};
    assign rem_sub = rem_sh - {1'b0, d_reg};
    // a square root divisor counts once
    assign pair    = (quo_reg == NB'(d_reg)) ? SB'(d_reg) : SB'(d_reg) + SB'(quo_reg);

    always_comb begin
        n_next   = n_reg;
        d_next   = d_reg;
        sq_next  = sq_reg;
        rem_next = rem_reg;
        quo_next = quo_reg;
        acc_next = acc_reg;
        sum_next = sum_reg;
        abn_next = abn_reg;

        if (cmd.load) begin
            n_next   = number;
            d_next   = DB'(2);
            sq_next  = QB'(4);
            // divisor 1 counts for every number above one
            acc_next = (number > NB'(1)) ? SB'(1) : '0;
        end
        if (cmd.div_start) begin
            rem_next = '0;
            quo_next = n_reg;
        end
        if (cmd.div_step) begin
            rem_next = rem_ge ? rem_sub[DB-1:0] : rem_sh[DB-1:0];
            quo_next = {quo_reg[NB-2:0], rem_ge};
        end
        if (cmd.accum) begin
            if (rem_reg == '0) begin
                acc_next = acc_reg + pair;
            end
            d_next  = d_reg + 1'b1;
            // (d+1)^2 = d^2 + 2d + 1
            sq_next = sq_reg + QB'({d_reg, 1'b0}) + QB'(1);
        end
        if (cmd.out_load) begin
            sum_next = acc_reg;
            abn_next = acc_reg > SB'(n_reg);
        end
    end

    assign status.sq_over = sq_reg > QB'(n_reg);
    assign divisor_sum    = sum_reg;
    assign abundant       = abn_reg;

endmodule
